/* design/hotp_code_verifier_unit_assert.svh */
// Assertion macros for the code verifier checker.
`ifndef HOTP_CODE_VERIFIER_UNIT_ASSERT_SVH
`define HOTP_CODE_VERIFIER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define HCV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcv check failed");
// Next-cycle implication checked outside reset.
`define HCV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcv check failed");
`endif

/* design/hcv_pkg.sv */
// ---------------------------------------------------------------------------
// hcv_pkg
// Shared types, constants and SHA-1 helpers for the code verifier.
// ---------------------------------------------------------------------------
package hcv_pkg;
  localparam int CODE_DIGITS = 6;
  localparam int CODE_W = 20;
  localparam int WORD_W = 31;

  function automatic logic [WORD_W-1:0] code_modulus();
    logic [WORD_W-1:0] m;
    m = WORD_W'(1);
    for (int i = 0; i < CODE_DIGITS; i++) m = WORD_W'(m * 10);
    return m;
  endfunction

  localparam logic [WORD_W-1:0] CODE_MOD = code_modulus();

  // Reciprocal of the modulus, floor(2^RECIP_SHIFT / CODE_MOD); the quotient
  // estimate it gives is exact or one low.
  localparam int RECIP_SHIFT = 51;
  localparam logic [31:0] CODE_RECIP = 32'((64'd1 << RECIP_SHIFT) / 64'(CODE_MOD));
  localparam int QUO_W = WORD_W + 32 - RECIP_SHIFT;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_MOD, ST_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       capture;  // latch input request
    logic       load;     // load message block, pass given by blk
    logic [1:0] blk;      // 0 ipad key, 1 inner tail, 2 opad key, 3 outer tail
    logic       round;    // run one SHA-1 round
    logic       fold;     // add working vars into chaining value
    logic       trunc;    // dynamic truncation
    logic       mod_step; // one step of the reciprocal remainder
    logic       emit;     // load output register
  } cmd_t;

  typedef struct packed {
    logic last_round;
    logic mod_last;
  } status_t;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction
endpackage

/* design/hcv_datapath.sv */
// ---------------------------------------------------------------------------
// hcv_datapath
// SHA-1 round engine, HMAC block sequencing, truncation and modulo unit.
// ---------------------------------------------------------------------------
module hcv_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [63:0]          key_upper,
  input  logic [15:0]          key_lower,
  input  logic [63:0]          moving_factor,
  input  logic [19:0]          submitted_code,
  input  hcv_pkg::cmd_t        cmd,
  output hcv_pkg::status_t     status,
  output logic [19:0]          expected_code,
  output logic                 code_matches
);
  import hcv_pkg::*;

  logic [63:0]  factor;
  logic [19:0]  submitted;
  logic [159:0] hv;       // chaining value
  logic [159:0] inner;    // inner digest
  logic [31:0]  a, b, c, d, e;
  logic [31:0]  w [16];
  logic [6:0]   rnd;
  logic [WORD_W-1:0] rem;
  logic [1:0]   mstep;
  logic [WORD_W+31:0] prod;
  logic [WORD_W-1:0]  qm;

  logic [79:0]  key;
  logic [511:0] blk_data;
  logic [31:0]  f, k, t, wn;
  logic [159:0] hsum;
  logic [3:0]   off;
  logic [31:0]  tword;
  logic [QUO_W-1:0] quo;

  assign key = {key_upper, key_lower};

  always_comb begin
    case (cmd.blk)
      2'd0: blk_data = {key ^ {10{8'h36}}, {54{8'h36}}};
      2'd1: blk_data = {factor, 8'h80, 376'd0, 64'd576};
      2'd2: blk_data = {key ^ {10{8'h5c}}, {54{8'h5c}}};
      default: blk_data = {inner, 8'h80, 280'd0, 64'd672};
    endcase
  end

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d); k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d; k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d; k = 32'hCA62C1D6;
    end
    t  = rol(a, 5) + f + e + k + w[0];
    wn = rol(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
  end

  assign hsum = {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c,
                 hv[63:32] + d, hv[31:0] + e};
  assign status.last_round = (rnd == 7'd79);
  assign status.mod_last   = (mstep == 2'd0);

  // Truncation runs in the final fold cycle, so it reads the folded sum.
  assign off   = hsum[3:0];
  assign tword = 32'(hsum >> (8 * (16 - int'(off))));
  assign quo   = prod[WORD_W+31 -: QUO_W];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      factor    <= moving_factor;
      submitted <= submitted_code;
    end
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) w[i] <= blk_data[511-32*i -: 32];
      if (cmd.blk == 2'd0 || cmd.blk == 2'd2) begin
        {a, b, c, d, e} <= {H0, H1, H2, H3, H4};
        hv <= {H0, H1, H2, H3, H4};
      end else begin
        {a, b, c, d, e} <= hv;
      end
      rnd <= 7'd0;
    end
    if (cmd.round) begin
      {a, b, c, d, e} <= {t, a, rol(b, 30), c, d};
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      rnd <= rnd + 7'd1;
    end
    if (cmd.fold) begin
      hv <= hsum;
      {a, b, c, d, e} <= hsum;
      if (cmd.blk == 2'd1) inner <= hsum;
    end
    if (cmd.trunc) begin
      mstep <= 2'd3;
      factor[WORD_W-1:0] <= tword[WORD_W-1:0];
    end
    if (cmd.mod_step) begin
      // Reciprocal multiply for the quotient, back-multiply, subtract, and
      // one correction when the estimate came out one low.
      case (mstep)
        2'd3: prod <= {32'd0, factor[WORD_W-1:0]} * {{WORD_W{1'b0}}, CODE_RECIP};
        2'd2: qm <= WORD_W'({{WORD_W{1'b0}}, quo} * {{QUO_W{1'b0}}, CODE_MOD});
        2'd1: rem <= factor[WORD_W-1:0] - qm;
        default: begin
          if (rem >= CODE_MOD) rem <= rem - CODE_MOD;
        end
      endcase
      mstep <= mstep - 2'd1;
    end
    if (cmd.emit) begin
      expected_code <= rem[19:0];
      code_matches  <= (rem[19:0] == submitted);
    end
  end

  logic unused;
  assign unused = rst;
endmodule

/* design/hcv_controller.sv */
// ---------------------------------------------------------------------------
// hcv_controller
// Sequences the four SHA-1 compressions, truncation, modulo and output.
// ---------------------------------------------------------------------------
module hcv_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  hcv_pkg::status_t  status,
  output hcv_pkg::cmd_t     cmd
);
  import hcv_pkg::*;

  state_t state, state_next;
  logic [1:0] blk, blk_next;
  logic out_valid_next;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; blk <= 2'd0; out_valid <= 1'b0;
    end else begin
      state <= state_next; blk <= blk_next; out_valid <= out_valid_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign in_stall = busy;

  always_comb begin
    state_next = state;
    blk_next = blk;
    cmd = '0;
    cmd.blk = blk;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1; blk_next = 2'd0; state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load = 1'b1; state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (status.last_round) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        blk_next = blk + 2'd1;
        if (blk == 2'd3) begin
          cmd.trunc = 1'b1; state_next = ST_MOD;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        // Wait for the output register to free up.
        if (!out_valid || !out_stall) begin
          cmd.emit = 1'b1; out_valid_next = 1'b1; state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

/* design/hotp_code_verifier_unit.sv */
// ---------------------------------------------------------------------------
// hotp_code_verifier_unit
// HMAC-SHA1 HOTP six-digit code check.
// ---------------------------------------------------------------------------
// Usage:
//   Write the 10-byte secret through cfg_we/cfg_index/cfg_data while idle
//   (index 0 key_upper, index 1 key_lower). A request is taken on in_valid
//   with in_stall low: moving_factor and submitted_code.
//   One result per request on out_valid/out_stall: expected_code and
//   code_matches.
// Sequence: four compressions of 1 load + 80 rounds + 1 fold each, then 4
//   modulo steps and 1 emit into the output register. A new request is not
//   taken before the last result has been emitted, since the single shared
//   SHA-1 round unit serves all four compressions.
// in_stall is high from acceptance until the result enters the output
//   register; a held result under out_stall keeps the block from finishing
//   the next request, which then waits in its last state.
// Reset (rst, synchronous) clears the key to zero and empties the output.
// ---------------------------------------------------------------------------
module hotp_code_verifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] moving_factor,
  input  logic [19:0] submitted_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] expected_code,
  output logic        code_matches
);
  import hcv_pkg::*;

  logic [63:0] key_upper;
  logic [15:0] key_lower;
  cmd_t    cmd;
  status_t status;

  // Key registers; two indexes cover the whole register list.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0; key_lower <= '0;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) key_upper <= cfg_data;
      else key_lower <= cfg_data[15:0];
    end
  end

  hcv_controller u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status, .cmd
  );

  hcv_datapath u_dp (
    .clk, .rst, .key_upper, .key_lower, .moving_factor, .submitted_code,
    .cmd, .status, .expected_code, .code_matches
  );
endmodule

/* design/hcv_checker.sv */
// ---------------------------------------------------------------------------
// hcv_checker
// Port-level checks for the code verifier, bound to the top level.
// ---------------------------------------------------------------------------
`include "hotp_code_verifier_unit_assert.svh"
module hcv_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [19:0] expected_code,
  input logic        code_matches
);
  `HCV_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `HCV_ASSERT_IMPL(a_code_range, out_valid, expected_code < 20'd1000000)
  `HCV_ASSERT_NEXT(a_hold, out_valid && out_stall,
                   out_valid && $stable(expected_code) && $stable(code_matches))
endmodule

bind hotp_code_verifier_unit hcv_checker u_hcv_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .expected_code, .code_matches
);
